// ----- hw/rtl/sacl_pkg.sv -----
`default_nettype none

package sacl_pkg;

    localparam int TAG_W = 30;
    localparam int SET_W = 16;
    localparam int MEM_W = 17;
    localparam int CYC_W = 18;
    localparam int AGE_W = 3;

    localparam logic [CYC_W-1:0] MEM_CYCLES = 18'd100;

    localparam logic [2:0] CFG_SETS_LOG2      = 3'd0;
    localparam logic [2:0] CFG_WAYS_LOG2      = 3'd1;
    localparam logic [2:0] CFG_BLOCK_LOG2     = 3'd2;
    localparam logic [2:0] CFG_WRITE_ALLOCATE = 3'd3;
    localparam logic [2:0] CFG_WRITE_THROUGH  = 3'd4;
    localparam logic [2:0] CFG_LRU_MODE       = 3'd5;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } lane_t;

    typedef struct packed {
        logic             store;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set;
        logic [1:0]       wl;
        logic [MEM_W-1:0] mem;
        logic             wt;
        logic             alloc;
        logic             lru;
    } req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/set_assoc_cache_lookup.sv -----
`default_nettype none

// Set-associative cache lookup with LRU or FIFO replacement.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// the write takes effect at that edge. Write registers only while idle.
// Request: action and address are taken at an edge where start is high and
// busy is low. Busy is high while the two-beat request queue is full.
// Result: hit, cycles and dirty_evict are valid for exactly one cycle while
// done is high; the receiver cannot hold them off.
// Flow: an accepted request waits in the queue while the back end is busy
// or has another beat ahead of it, is read in the back end's read phase,
// then executed and written back, and its result is registered with done.
// The next access is read only after the single-port row store is written back.
// Reset clears the configuration to its defaults and marks every set empty
// at once through one valid flop per set row; no clearing pass is needed.

module set_assoc_cache_lookup
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [3:0]       cfg_data,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             action,
    input  wire logic [31:0]      address,
    output logic                  done,
    output logic                  hit,
    output logic [CYC_W-1:0]      cycles,
    output logic                  dirty_evict
);

    localparam int SETS_LG = $clog2(MAX_SETS + 1) - 1;
    localparam int WAYS_LG = $clog2(MAX_WAYS + 1) - 1;

    logic [3:0] sets_log2_reg;
    logic [1:0] ways_log2_reg;
    logic [3:0] block_log2_reg;
    logic       write_allocate_reg;
    logic       write_through_reg;
    logic       lru_mode_reg;

    req_t       front_req;
    req_t       q_head;
    logic       q_empty;
    logic       q_full;
    logic       q_pop;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_log2_reg      <= 4'd0;
            ways_log2_reg      <= 2'd0;
            block_log2_reg     <= 4'd4;
            write_allocate_reg <= 1'b1;
            write_through_reg  <= 1'b0;
            lru_mode_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SETS_LOG2:      sets_log2_reg      <= cfg_data;
                CFG_WAYS_LOG2:      ways_log2_reg      <= cfg_data[1:0];
                CFG_BLOCK_LOG2:     block_log2_reg     <= cfg_data;
                CFG_WRITE_ALLOCATE: write_allocate_reg <= cfg_data[0];
                CFG_WRITE_THROUGH:  write_through_reg  <= cfg_data[0];
                CFG_LRU_MODE:       lru_mode_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !q_full;

    sacl_front #(
        .SETS_LG (SETS_LG),
        .WAYS_LG (WAYS_LG)
    ) u_front (
        .action         (action),
        .address        (address),
        .sets_log2      (sets_log2_reg),
        .ways_log2      (ways_log2_reg),
        .block_log2     (block_log2_reg),
        .write_allocate (write_allocate_reg),
        .write_through  (write_through_reg),
        .lru_mode       (lru_mode_reg),
        .req            (front_req)
    );

    sacl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_req),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    sacl_back #(
        .SETS_LG (SETS_LG),
        .WAYS_LG (WAYS_LG)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .done        (done),
        .hit         (hit),
        .cycles      (cycles),
        .dirty_evict (dirty_evict)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sacl_front.sv -----
`default_nettype none

module sacl_front
    import sacl_pkg::*;
#(
    parameter int SETS_LG = 8,
    parameter int WAYS_LG = 3
) (
    input  wire logic        action,
    input  wire logic [31:0] address,
    input  wire logic [3:0]  sets_log2,
    input  wire logic [1:0]  ways_log2,
    input  wire logic [3:0]  block_log2,
    input  wire logic        write_allocate,
    input  wire logic        write_through,
    input  wire logic        lru_mode,
    output req_t             req
);

    localparam logic [4:0] SL_MAX = 5'(SETS_LG);
    localparam logic [1:0] WL_MAX = (WAYS_LG > 3) ? 2'd3 : 2'(WAYS_LG);

    logic [4:0]  sl;
    logic [3:0]  bl;
    logic [31:0] set_mask;
    logic [31:0] shifted;
    logic [31:0] tag_full;

    always_comb
    begin
        sl = ({1'b0, sets_log2} > SL_MAX) ? SL_MAX : {1'b0, sets_log2};
        if (block_log2 < 4'd2)
        begin
            bl = 4'd2;
        end
        else if (block_log2 > 4'd12)
        begin
            bl = 4'd12;
        end
        else
        begin
            bl = block_log2;
        end
        set_mask = (32'd1 << sl) - 32'd1;
        shifted  = address >> bl;
        tag_full = address >> (6'(bl) + 6'(sl));

        req.store = action;
        req.tag   = tag_full[TAG_W-1:0];
        req.set   = SET_W'(shifted & set_mask);
        req.wl    = (ways_log2 > WL_MAX) ? WL_MAX : ways_log2;
        req.mem   = MEM_W'(MEM_CYCLES) << (bl - 4'd2);
        req.wt    = write_through | ~write_allocate;
        req.alloc = write_allocate;
        req.lru   = lru_mode;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sacl_queue.sv -----
`default_nettype none

module sacl_queue
    import sacl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  req_t      push_data,
    input  wire logic pop,
    output req_t      head,
    output logic      empty,
    output logic      full
);

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sacl_back.sv -----
`default_nettype none

module sacl_back
    import sacl_pkg::*;
#(
    parameter int SETS_LG = 8,
    parameter int WAYS_LG = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  req_t                  q_head,
    output logic                  q_pop,
    output logic                  done,
    output logic                  hit,
    output logic [CYC_W-1:0]      cycles,
    output logic                  dirty_evict
);

    localparam int L    = 1 << WAYS_LG;
    localparam int ROWS = 1 << SETS_LG;
    localparam int RW   = (SETS_LG > 0) ? SETS_LG : 1;
    localparam int LW   = (WAYS_LG > 0) ? WAYS_LG : 1;
    localparam int FW   = SETS_LG + WAYS_LG + 1;

    localparam logic PH_RD = 1'b0;
    localparam logic PH_EX = 1'b1;

    typedef lane_t [L-1:0] row_t;

    row_t             row_mem [ROWS];
    row_t             rd_data_reg;
    logic [ROWS-1:0]  init_reg;
    logic             phase_reg;
    logic             cur_init_reg;
    req_t             cur_reg;
    logic [RW-1:0]    cur_row_reg;
    logic [LW-1:0]    cur_off_reg;
    logic             done_reg;
    logic             hit_reg;
    logic [CYC_W-1:0] cycles_reg;
    logic             devict_reg;

    logic [FW-1:0]    hd_flat;
    logic [RW-1:0]    hd_row;
    logic [LW-1:0]    hd_off;
    logic             wr_en;

    row_t             old_row;
    row_t             new_row;
    logic             ex_hit;
    logic             ex_devict;
    logic [CYC_W-1:0] ex_cycles;

    assign q_pop = (phase_reg == PH_RD) && !q_empty;
    assign wr_en = (phase_reg == PH_EX);

    always_comb
    begin
        hd_flat = FW'(q_head.set) << q_head.wl;
        hd_row  = hd_flat[WAYS_LG +: RW];
        hd_off  = (WAYS_LG == 0) ? '0 : hd_flat[LW-1:0];
    end

    always_comb
    begin
        logic [LW-1:0]    wmask;
        logic [L-1:0]     ingrp;
        logic [LW-1:0]    hl;
        logic [LW-1:0]    el;
        logic [LW-1:0]    vl;
        logic             empty_found;
        logic             victim_found;
        logic [AGE_W-1:0] vage;
        logic [AGE_W-1:0] ref_age;
        logic [LW-1:0]    chosen;
        logic             do_promote;
        logic             do_fill;

        wmask        = LW'((32'd1 << cur_reg.wl) - 32'd1);
        hl           = '0;
        el           = '0;
        vl           = '0;
        ex_hit       = 1'b0;
        empty_found  = 1'b0;
        victim_found = 1'b0;
        vage         = '0;
        ex_devict    = 1'b0;
        ex_cycles    = '0;
        do_promote   = 1'b0;
        do_fill      = 1'b0;
        chosen       = '0;
        ref_age      = AGE_W'((32'd1 << cur_reg.wl) - 32'd1);

        for (int l = 0; l < L; l++)
        begin
            old_row[l] = rd_data_reg[l];
            if (!cur_init_reg)
            begin
                old_row[l].valid = 1'b0;
                old_row[l].dirty = 1'b0;
                old_row[l].age   = '0;
            end
            ingrp[l] = ((LW'(l) & ~wmask) == cur_off_reg);
        end

        for (int l = L - 1; l >= 0; l--)
        begin
            if (ingrp[l] && old_row[l].valid && old_row[l].tag == cur_reg.tag)
            begin
                ex_hit = 1'b1;
                hl     = LW'(l);
            end
            if (ingrp[l] && !old_row[l].valid)
            begin
                empty_found = 1'b1;
                el          = LW'(l);
            end
        end

        for (int l = 0; l < L; l++)
        begin
            if (ingrp[l] && (!victim_found || old_row[l].age > vage))
            begin
                victim_found = 1'b1;
                vl           = LW'(l);
                vage         = old_row[l].age;
            end
        end

        new_row = old_row;

        if (ex_hit)
        begin
            if (cur_reg.store && cur_reg.wt)
            begin
                ex_cycles = MEM_CYCLES;
            end
            else
            begin
                ex_cycles = 18'd1;
            end
            if (cur_reg.store && !cur_reg.wt)
            begin
                new_row[hl].dirty = 1'b1;
            end
            chosen     = hl;
            ref_age    = old_row[hl].age;
            do_promote = cur_reg.lru;
        end
        else if (cur_reg.store && !cur_reg.alloc)
        begin
            ex_cycles = MEM_CYCLES;
        end
        else
        begin
            do_fill    = 1'b1;
            do_promote = 1'b1;
            if (empty_found)
            begin
                chosen = el;
            end
            else
            begin
                chosen    = vl;
                ref_age   = vage;
                ex_devict = old_row[vl].dirty;
            end
            if (cur_reg.store && cur_reg.wt)
            begin
                ex_cycles = MEM_CYCLES + CYC_W'(cur_reg.mem);
            end
            else
            begin
                ex_cycles = CYC_W'(cur_reg.mem);
            end
            if (ex_devict)
            begin
                ex_cycles = ex_cycles + CYC_W'(cur_reg.mem);
            end
        end

        if (do_promote)
        begin
            for (int l = 0; l < L; l++)
            begin
                if (ingrp[l] && LW'(l) != chosen && old_row[l].valid
                    && old_row[l].age < ref_age)
                begin
                    new_row[l].age = old_row[l].age + AGE_W'(1);
                end
            end
            new_row[chosen].age = '0;
        end

        if (do_fill)
        begin
            new_row[chosen].tag   = cur_reg.tag;
            new_row[chosen].valid = 1'b1;
            new_row[chosen].dirty = cur_reg.store && !cur_reg.wt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RD;
            done_reg     <= 1'b0;
            init_reg     <= '0;
            cur_init_reg <= 1'b0;
        end
        else
        begin
            done_reg <= wr_en;
            if (q_pop)
            begin
                phase_reg    <= PH_EX;
                cur_init_reg <= init_reg[hd_row];
            end
            else if (wr_en)
            begin
                phase_reg <= PH_RD;
            end
            if (wr_en)
            begin
                init_reg[cur_row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= row_mem[hd_row];
            cur_reg     <= q_head;
            cur_row_reg <= hd_row;
            cur_off_reg <= hd_off;
        end
        if (wr_en)
        begin
            row_mem[cur_row_reg] <= new_row;
            hit_reg              <= ex_hit;
            cycles_reg           <= ex_cycles;
            devict_reg           <= ex_devict;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign cycles      = cycles_reg;
    assign dirty_evict = devict_reg;

`ifndef NO_ASSERTIONS
    a_done_after_ex: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(phase_reg == PH_EX))
        else $error("result beat without an execute cycle");

    a_ex_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EX) |=> (phase_reg == PH_RD))
        else $error("execute phase held for more than one cycle");

    a_pending_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RD && !q_empty) |=> (phase_reg == PH_EX))
        else $error("queued access not issued");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sacl_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [CYC_W-1:0] cycles;
        logic             devict;
    } access_res_t;

    typedef struct {
        logic        act;
        logic [31:0] adr;
        bit          typed;
        access_res_t res;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [3:0]       cfg_data;
    logic             start;
    logic             busy;
    logic             action;
    logic [31:0]      address;
    logic             done;
    logic             hit;
    logic [CYC_W-1:0] cycles;
    logic             dirty_evict;

    set_assoc_cache_lookup dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .action(action),
        .address(address), .done(done), .hit(hit), .cycles(cycles),
        .dirty_evict(dirty_evict)
    );

    logic [TAG_W-1:0] line_tag [2048];
    bit               line_valid [2048];
    bit               line_dirty [2048];
    int               line_age [2048];
    int               geo_sets, geo_ways, geo_block;
    bit               pol_alloc, pol_wt, pol_lru;

    access_res_t      pending_results[$];
    int               mismatches;
    int               accesses;
    int               hit_count;
    int               evict_count;
    int               idle_cycles;
    logic [31:0]      line_pool [24];
    stim_row_t        rows [8];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic int fit_log2(int lg, int limit);
        while (lg > 0 && (lg > 16 || (1 << lg) > limit))
            lg--;
        return lg;
    endfunction

    function automatic void age_ways(int base, int ways, int chosen, int ref_age);
        for (int w = 0; w < ways; w++)
        begin
            if (w != chosen && line_valid[base + w] && line_age[base + w] < ref_age)
                line_age[base + w] = line_age[base + w] + 1;
        end
        line_age[base + chosen] = 0;
    endfunction

    function automatic access_res_t cache_access(logic st, logic [31:0] adr);
        access_res_t r;
        int sl, wl, bl, ways, set_i, base, mem, way, ref_age;
        logic [TAG_W-1:0] tg;
        bit wt, found, empty;
        sl = fit_log2(geo_sets, 256);
        wl = fit_log2(geo_ways, 8);
        bl = geo_block < 2 ? 2 : (geo_block > 12 ? 12 : geo_block);
        ways = 1 << wl;
        set_i = int'((adr >> bl) & ((32'd1 << sl) - 32'd1));
        tg = TAG_W'(adr >> (bl + sl));
        base = set_i * ways;
        mem = ((1 << bl) / 4) * 100;
        wt = pol_wt || !pol_alloc;
        found = 0;
        empty = 0;
        way = 0;
        r = '0;
        for (int w = 0; w < ways; w++)
        begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tg)
            begin
                found = 1;
                way = w;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (st && wt)
                r.cycles = MEM_CYCLES;
            else
                r.cycles = 18'd1;
            if (st && !wt)
                line_dirty[base + way] = 1;
            if (pol_lru)
                age_ways(base, ways, way, line_age[base + way]);
        end
        else if (st && !pol_alloc)
        begin
            r.cycles = MEM_CYCLES;
        end
        else
        begin
            for (int w = ways - 1; w >= 0; w--)
            begin
                if (!line_valid[base + w])
                begin
                    empty = 1;
                    way = w;
                end
            end
            if (empty)
                ref_age = ways - 1;
            else
            begin
                way = 0;
                for (int w = 1; w < ways; w++)
                begin
                    if (line_age[base + w] > line_age[base + way])
                        way = w;
                end
                ref_age = line_age[base + way];
                if (line_dirty[base + way])
                begin
                    r.devict = 1'b1;
                    r.cycles = CYC_W'(mem);
                end
            end
            if (st && wt)
                r.cycles = r.cycles + CYC_W'(100 + mem);
            else
                r.cycles = r.cycles + CYC_W'(mem);
            age_ways(base, ways, way, ref_age);
            line_tag[base + way] = tg;
            line_valid[base + way] = 1;
            line_dirty[base + way] = st && !wt;
        end
        return r;
    endfunction

    task automatic issue(input logic act, input logic [31:0] adr, input bit typed,
                         input access_res_t typed_res);
        access_res_t r;
        start <= 1'b1;
        action <= act;
        address <= adr;
        do
            @(posedge clk);
        while (busy);
        r = cache_access(act, adr);
        pending_results.push_back(typed ? typed_res : r);
        accesses++;
    endtask

    task automatic pause_until_empty();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SETS_LOG2:      geo_sets = val;
            CFG_WAYS_LOG2:      geo_ways = val[1:0];
            CFG_BLOCK_LOG2:     geo_block = val;
            CFG_WRITE_ALLOCATE: pol_alloc = val[0];
            CFG_WRITE_THROUGH:  pol_wt = val[0];
            CFG_LRU_MODE:       pol_lru = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int s, input int w, input int b, input bit wa,
                             input bit wt, input bit lru);
        write_reg(CFG_SETS_LOG2, 4'(s));
        write_reg(CFG_WAYS_LOG2, 4'(w));
        write_reg(CFG_BLOCK_LOG2, 4'(b));
        write_reg(CFG_WRITE_ALLOCATE, 4'(wa));
        write_reg(CFG_WRITE_THROUGH, 4'(wt));
        write_reg(CFG_LRU_MODE, 4'(lru));
        write_reg(3'd6 + 3'($urandom_range(0, 1)), 4'($urandom));
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        access_res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit=%0b cycles=%0d dirty_evict=%0b",
                             hit, cycles, dirty_evict);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit || cycles !== want.cycles
                    || dirty_evict !== want.devict)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0b cycles=%0d dirty_evict=%0b, %s",
                                 want.hit, want.cycles, want.devict,
                                 $sformatf("got hit=%0b cycles=%0d dirty_evict=%0b",
                                           hit, cycles, dirty_evict));
                end
                hit_count += want.hit;
                evict_count += want.devict;
            end
        end
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] adr;
        logic        act;
        bit          quiet;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        action = 1'b0;
        address = '0;
        mismatches = 0;
        accesses = 0;
        hit_count = 0;
        evict_count = 0;
        idle_cycles = 0;
        for (int i = 0; i < 2048; i++)
        begin
            line_tag[i] = '0;
            line_valid[i] = 0;
            line_dirty[i] = 0;
            line_age[i] = 0;
        end
        geo_sets = 0;
        geo_ways = 0;
        geo_block = 4;
        pol_alloc = 1;
        pol_wt = 0;
        pol_lru = 1;

        // One set, one way, 16-byte blocks after reset: a miss costs 400.
        rows[0] = '{1'b0, 32'h0000_0000, 1, '{1'b0, 18'd400, 1'b0}};
        rows[1] = '{1'b0, 32'h0000_0000, 1, '{1'b1, 18'd1, 1'b0}};
        rows[2] = '{1'b1, 32'hFFFF_FFFF, 1, '{1'b0, 18'd400, 1'b0}};
        rows[3] = '{1'b0, 32'h0000_0000, 1, '{1'b0, 18'd800, 1'b1}};
        rows[4] = '{1'b1, 32'h0000_0000, 1, '{1'b1, 18'd1, 1'b0}};
        rows[5] = '{1'b0, 32'h0000_0010, 1, '{1'b0, 18'd800, 1'b1}};
        rows[6] = '{1'b1, 32'h0000_0010, 0, '0};
        rows[7] = '{1'b0, 32'hFFFF_FFF0, 0, '0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            issue(rows[i].act, rows[i].adr, rows[i].typed, rows[i].res);

        for (int phase = 0; phase < 10; phase++)
        begin
            pause_until_empty();
            case (phase)
                0: configure(0, 0, 2, 1, 1, 0);
                1: configure(15, 3, 15, 1, 0, 1);
                2: configure(2, 3, 0, 0, 0, 1);
                3: configure(8, 2, 12, 1, 1, 1);
                4: configure(3, 3, 2, 1, 0, 0);
                5: configure(1, 3, 13, 1, 1, 0);
                default: configure($urandom_range(0, 15), $urandom_range(0, 3),
                                   $urandom_range(0, 15), $urandom_range(0, 1),
                                   $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            foreach (line_pool[i])
                line_pool[i] = $urandom;
            for (int n = 0; n < 160; n++)
            begin
                quiet = (phase == 9);
                if (n == 80 && phase == 4)
                    pause_until_empty();
                else if (!quiet && $urandom_range(0, 4) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
                if ($urandom_range(0, 4) == 0)
                    adr = $urandom;
                else
                    adr = line_pool[$urandom_range(0, 23)] ^ 32'($urandom_range(0, 15));
                act = 1'($urandom);
                issue(act, adr, 0, '0);
            end
        end

        pause_until_empty();
        $display("%0d accesses over ten geometries and policies, %0d hits, %0d dirty evictions",
                 accesses, hit_count, evict_count);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_front.sv
hw/rtl/sacl_queue.sv
hw/rtl/sacl_back.sv
hw/rtl/set_assoc_cache_lookup.sv
tb/testbench.sv
